// File: hw/rtl/sha1sh_pkg.sv
// ----------------------------------------------------------------------------
// sha1sh_pkg
// Types, constants and round functions shared by the streaming SHA-1 core.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1sh_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_PAD_LEN,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  // message schedule operations
  typedef enum logic [2:0] {
    SCH_HOLD,
    SCH_WRITE,
    SCH_PAD,
    SCH_LEN,
    SCH_SHIFT
  } sch_op_t;

  // round unit operations
  typedef enum logic [2:0] {
    RND_HOLD,
    RND_LOAD,
    RND_STEP,
    RND_UPDATE,
    RND_INIT
  } rnd_op_t;

  // request function codes
  localparam logic FUNC_ABSORB = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  // round stage codes
  localparam logic [1:0] STG_CHOOSE = 2'd0;
  localparam logic [1:0] STG_PARITY1 = 2'd1;
  localparam logic [1:0] STG_MAJORITY = 2'd2;
  localparam logic [1:0] STG_PARITY2 = 2'd3;

  localparam int NUM_WORDS = 5;
  localparam int WIN_WORDS = 16;

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [6:0] STG1_ROUND = 7'd20;
  localparam logic [6:0] STG2_ROUND = 7'd40;
  localparam logic [6:0] STG3_ROUND = 7'd60;
  localparam logic [2:0] LAST_WORD = 3'd4;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [NUM_WORDS-1:0][31:0] chain_t;

  // word 0 sits at the low index
  localparam chain_t INIT_CHAIN = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                   32'hefcdab89, 32'h67452301};

  typedef struct packed {
    sch_op_t     op;
    logic [5:0]  pos;
    logic [7:0]  data;
    logic [63:0] bit_len;
  } sch_ctrl_t;

  typedef struct packed {
    rnd_op_t    op;
    logic [1:0] stage;
  } rnd_ctrl_t;

  function automatic logic [31:0] round_k(input logic [1:0] stage);
    logic [31:0] k;
    case (stage)
      STG_CHOOSE:   k = 32'h5a827999;
      STG_PARITY1:  k = 32'h6ed9eba1;
      STG_MAJORITY: k = 32'h8f1bbcdc;
      STG_PARITY2:  k = 32'hca62c1d6;
      default:      k = 32'h5a827999;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [1:0] stage, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (stage)
      STG_CHOOSE:   f = (b & c) | (~b & d);
      STG_MAJORITY: f = (b & c) | (b & d) | (c & d);
      STG_PARITY1:  f = b ^ c ^ d;
      STG_PARITY2:  f = b ^ c ^ d;
      default:      f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sha1sh_if.sv
// ----------------------------------------------------------------------------
// sha1sh_if
// Valid/ready channels for message requests and digest words.
// ----------------------------------------------------------------------------
`default_nettype none

interface sha1sh_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink (input valid, input func, input data_byte, output ready);
endinterface

interface sha1sh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;

  modport source (output valid, output digest_word, output word_index, output last,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last,
                output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sha1sh_sched.sv
// ----------------------------------------------------------------------------
// sha1sh_sched
// Block buffer and message schedule: a 16-word window that gathers bytes,
// applies padding and slides one expanded word per round.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1sh_sched
  import sha1sh_pkg::*;
(
  input  wire logic        clk,
  input  wire sch_ctrl_t   ctrl,
  output logic [31:0]      wt
);

  logic [WIN_WORDS-1:0][31:0] win_r;
  logic [WIN_WORDS-1:0][31:0] win_nxt;
  logic [31:0]                mix;

  // next expanded word from the window taps
  assign mix = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];

  // window update
  always_comb begin
    win_nxt = win_r;
    case (ctrl.op)
      SCH_WRITE: begin
        for (int l = 0; l < 4; l++) begin
          if (ctrl.pos[1:0] == 2'(l)) begin
            win_nxt[ctrl.pos[5:2]][8*(3-l) +: 8] = ctrl.data;
          end
        end
      end
      SCH_PAD: begin
        for (int w = 0; w < WIN_WORDS; w++) begin
          for (int l = 0; l < 4; l++) begin
            if (6'(4*w + l) == ctrl.pos) begin
              win_nxt[w][8*(3-l) +: 8] = PAD_BYTE;
            end else if (6'(4*w + l) > ctrl.pos) begin
              win_nxt[w][8*(3-l) +: 8] = 8'h00;
            end
          end
        end
        // length fits behind the pad byte
        if (ctrl.pos < LEN_POS) begin
          win_nxt[WIN_WORDS-2] = ctrl.bit_len[63:32];
          win_nxt[WIN_WORDS-1] = ctrl.bit_len[31:0];
        end
      end
      SCH_LEN: begin
        win_nxt                = '0;
        win_nxt[WIN_WORDS-2] = ctrl.bit_len[63:32];
        win_nxt[WIN_WORDS-1] = ctrl.bit_len[31:0];
      end
      SCH_SHIFT: begin
        for (int i = 0; i < WIN_WORDS - 1; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[WIN_WORDS-1] = {mix[30:0], mix[31]};
      end
      default: begin
        win_nxt = win_r;
      end
    endcase
  end

  // window storage
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  assign wt = win_r[0];

endmodule

`default_nettype wire

// File: hw/rtl/sha1sh_round.sv
// ----------------------------------------------------------------------------
// sha1sh_round
// Shared round unit: working variables a..e, one round per cycle, and the
// five chaining words with their final feed-forward add.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1sh_round
  import sha1sh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire rnd_ctrl_t   ctrl,
  input  wire logic [31:0] wt,
  output chain_t           chain
);

  chain_t      chain_r;
  chain_t      chain_nxt;
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [31:0] tmp;

  // round sum
  assign tmp = {a_r[26:0], a_r[31:27]} + round_f(ctrl.stage, b_r, c_r, d_r) + e_r
             + round_k(ctrl.stage) + wt;

  // working variable and chain update
  always_comb begin
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    e_nxt     = e_r;
    chain_nxt = chain_r;
    case (ctrl.op)
      RND_LOAD: begin
        a_nxt = chain_r[0];
        b_nxt = chain_r[1];
        c_nxt = chain_r[2];
        d_nxt = chain_r[3];
        e_nxt = chain_r[4];
      end
      RND_STEP: begin
        a_nxt = tmp;
        b_nxt = a_r;
        c_nxt = {b_r[1:0], b_r[31:2]};
        d_nxt = c_r;
        e_nxt = d_r;
      end
      RND_UPDATE: begin
        chain_nxt[0] = chain_r[0] + a_r;
        chain_nxt[1] = chain_r[1] + b_r;
        chain_nxt[2] = chain_r[2] + c_r;
        chain_nxt[3] = chain_r[3] + d_r;
        chain_nxt[4] = chain_r[4] + e_r;
      end
      RND_INIT: begin
        chain_nxt = INIT_CHAIN;
      end
      default: begin
        chain_nxt = chain_r;
      end
    endcase
  end

  // chaining words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= INIT_CHAIN;
    end else begin
      chain_r <= chain_nxt;
    end
  end

  // working variables
  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    d_r <= d_nxt;
    e_r <= e_nxt;
  end

  assign chain = chain_r;

endmodule

`default_nettype wire

// File: hw/rtl/sha1_stream_hash_core.sv
// Each data byte is taken in ST_IDLE; every 64th byte starts a compression
// (80 rounds of the shared round unit, then the feed-forward add), ready low meanwhile.
// Finish: a pad step and one compression, plus a second one after a length-only block
// when over 55 tail bytes need it, then five digest words at one per cycle as the sink takes them.
// Throughput is set by the single round unit: no byte is taken while a block is compressed.
// Reset (synchronous, rst_n low): initial chaining words, byte count zero, idle.
// ----------------------------------------------------------------------------
// sha1_stream_hash_core
// Streaming SHA-1: gathers bytes into 64-byte blocks, compresses each block
// over 80 rounds, pads on finish and returns the 160-bit digest as 5 words.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_stream_hash_core
  import sha1sh_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  sha1sh_in_if.sink    in_ch,
  sha1sh_out_if.source out_ch
);

  state_t      state_r, state_nxt;
  logic [6:0]  rnd_cnt_r, rnd_cnt_nxt;
  logic        fin_r, fin_nxt;
  logic        extra_r, extra_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [63:0] count_r, count_nxt;
  logic        in_take;
  logic        out_take;
  logic [5:0]  pos;
  sch_ctrl_t   sch_ctrl;
  rnd_ctrl_t   rnd_ctrl;
  logic [31:0] wt;
  chain_t      chain;
  logic [1:0]  stage;

  assign pos      = count_r[5:0];
  assign in_take  = in_ch.valid && in_ch.ready;
  assign out_take = out_ch.valid && out_ch.ready;

  // round stage from round count
  always_comb begin
    if (rnd_cnt_r < STG1_ROUND) begin
      stage = STG_CHOOSE;
    end else if (rnd_cnt_r < STG2_ROUND) begin
      stage = STG_PARITY1;
    end else if (rnd_cnt_r < STG3_ROUND) begin
      stage = STG_MAJORITY;
    end else begin
      stage = STG_PARITY2;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          if (in_ch.func == FUNC_FINISH) begin
            state_nxt = ST_PAD;
          end else if (pos == LAST_POS) begin
            state_nxt = ST_ROUND;
          end
        end
      end
      ST_PAD:     state_nxt = ST_ROUND;
      ST_PAD_LEN: state_nxt = ST_ROUND;
      ST_ROUND: begin
        if (rnd_cnt_r == LAST_ROUND) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (extra_r) begin
          state_nxt = ST_PAD_LEN;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_take && idx_r == LAST_WORD) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // unit controls and handshake outputs
  always_comb begin
    in_ch.ready      = 1'b0;
    out_ch.valid     = 1'b0;
    sch_ctrl.op      = SCH_HOLD;
    sch_ctrl.pos     = pos;
    sch_ctrl.data    = in_ch.data_byte;
    sch_ctrl.bit_len = {count_r[60:0], 3'b000};
    rnd_ctrl.op      = RND_HOLD;
    rnd_ctrl.stage   = stage;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_take && in_ch.func == FUNC_ABSORB) begin
          sch_ctrl.op = SCH_WRITE;
          if (pos == LAST_POS) begin
            rnd_ctrl.op = RND_LOAD;
          end
        end
      end
      ST_PAD: begin
        sch_ctrl.op = SCH_PAD;
        rnd_ctrl.op = RND_LOAD;
      end
      ST_PAD_LEN: begin
        sch_ctrl.op = SCH_LEN;
        rnd_ctrl.op = RND_LOAD;
      end
      ST_ROUND: begin
        sch_ctrl.op = SCH_SHIFT;
        rnd_ctrl.op = RND_STEP;
      end
      ST_UPDATE: begin
        rnd_ctrl.op = RND_UPDATE;
      end
      ST_EMIT: begin
        out_ch.valid = 1'b1;
        if (out_take && idx_r == LAST_WORD) begin
          rnd_ctrl.op = RND_INIT;
        end
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  // counters and message flags
  always_comb begin
    rnd_cnt_nxt = rnd_cnt_r;
    fin_nxt     = fin_r;
    extra_nxt   = extra_r;
    idx_nxt     = idx_r;
    count_nxt   = count_r;
    case (state_r)
      ST_IDLE: begin
        rnd_cnt_nxt = '0;
        idx_nxt     = '0;
        if (in_take) begin
          if (in_ch.func == FUNC_FINISH) begin
            fin_nxt   = 1'b1;
            extra_nxt = (pos >= LEN_POS);
          end else begin
            count_nxt = count_r + 64'd1;
          end
        end
      end
      ST_PAD_LEN: begin
        extra_nxt   = 1'b0;
        rnd_cnt_nxt = '0;
      end
      ST_ROUND: begin
        rnd_cnt_nxt = rnd_cnt_r + 7'd1;
      end
      ST_UPDATE: begin
        rnd_cnt_nxt = '0;
      end
      ST_EMIT: begin
        if (out_take) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == LAST_WORD) begin
            fin_nxt   = 1'b0;
            count_nxt = '0;
          end
        end
      end
      default: begin
        rnd_cnt_nxt = rnd_cnt_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rnd_cnt_r <= '0;
      fin_r     <= 1'b0;
      extra_r   <= 1'b0;
      idx_r     <= '0;
      count_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      rnd_cnt_r <= rnd_cnt_nxt;
      fin_r     <= fin_nxt;
      extra_r   <= extra_nxt;
      idx_r     <= idx_nxt;
      count_r   <= count_nxt;
    end
  end

  // digest word select
  always_comb begin
    case (idx_r)
      3'd0:    out_ch.digest_word = chain[0];
      3'd1:    out_ch.digest_word = chain[1];
      3'd2:    out_ch.digest_word = chain[2];
      3'd3:    out_ch.digest_word = chain[3];
      3'd4:    out_ch.digest_word = chain[4];
      default: out_ch.digest_word = chain[0];
    endcase
  end

  assign out_ch.word_index = idx_r;
  assign out_ch.last       = (idx_r == LAST_WORD);

  sha1sh_sched u_sched (
    .clk  (clk),
    .ctrl (sch_ctrl),
    .wt   (wt)
  );

  sha1sh_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (rnd_ctrl),
    .wt    (wt),
    .chain (chain)
  );

endmodule

`default_nettype wire

// File: bench/sha1sh_digest_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha1sh_digest_checker
// Watches the message and digest channels of the SHA-1 core, keeps its own
// running SHA-1 state, queues the five digest words of every finish request
// and compares each delivered word against the oldest queued one.
// ----------------------------------------------------------------------------

module sha1sh_digest_checker
  import sha1sh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_cnt
);

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_exp_t;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hc3d2e1f0;

  logic [31:0]  hash_words [5];
  logic [511:0] msg_block;
  logic [63:0]  msg_bytes;
  digest_exp_t  digest_q [$];
  digest_exp_t  exp_word;
  int           errors;

  function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // one 80-round compression of a 512-bit block, byte 0 in the top bits
  task automatic compress_block(input logic [511:0] blk);
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, tmp;
    int t;
    for (t = 0; t < 16; t++) w[t] = blk[511 - 32 * t -: 32];
    for (t = 16; t < 80; t++) w[t] = rol32(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
    a = hash_words[0];
    b = hash_words[1];
    c = hash_words[2];
    d = hash_words[3];
    e = hash_words[4];
    for (t = 0; t < 80; t++) begin
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5a827999;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ed9eba1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8f1bbcdc;
      end else begin
        f = b ^ c ^ d;
        k = 32'hca62c1d6;
      end
      tmp = rol32(a, 5) + f + e + k + w[t];
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = tmp;
    end
    hash_words[0] += a;
    hash_words[1] += b;
    hash_words[2] += c;
    hash_words[3] += d;
    hash_words[4] += e;
  endtask

  task automatic restart_message();
    hash_words[0] = IV0;
    hash_words[1] = IV1;
    hash_words[2] = IV2;
    hash_words[3] = IV3;
    hash_words[4] = IV4;
    msg_bytes = '0;
  endtask

  // absorb one message byte, compress on a full block
  task automatic absorb_byte(input logic [7:0] data);
    int pos;
    pos = int'(msg_bytes[5:0]);
    msg_block[511 - 8 * pos -: 8] = data;
    msg_bytes = msg_bytes + 64'd1;
    if (pos == 63) compress_block(msg_block);
  endtask

  // pad, append the bit length, queue the digest and start over
  task automatic finish_message();
    int pos;
    int i;
    logic [63:0] bit_len;
    digest_exp_t ent;
    pos = int'(msg_bytes[5:0]);
    bit_len = msg_bytes << 3;
    msg_block[511 - 8 * pos -: 8] = 8'h80;
    for (i = pos + 1; i < 64; i++) msg_block[511 - 8 * i -: 8] = 8'h00;
    if (pos >= 56) begin
      // tail too long for the length field: one extra block
      compress_block(msg_block);
      compress_block({448'd0, bit_len});
    end else begin
      msg_block[63:0] = bit_len;
      compress_block(msg_block);
    end
    for (i = 0; i < 5; i++) begin
      ent.word = hash_words[i];
      ent.idx  = 3'(i);
      ent.last = (i == 4);
      digest_q.push_back(ent);
    end
    restart_message();
  endtask

  initial begin
    errors = 0;
    fail_count = 0;
    pending_cnt = 0;
    msg_block = '0;
    restart_message();
  end

  // track requests and compare digest words at each accepting edge
  always @(posedge clk) begin
    if (!rst_n) begin
      restart_message();
      digest_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected digest word: expected none, actual %h idx %0d last %0b",
                   $time, out_digest_word, out_word_index, out_last);
        end else begin
          exp_word = digest_q.pop_front();
          if (out_digest_word !== exp_word.word) begin
            errors++;
            $display("%0t: digest_word mismatch: expected %h, actual %h",
                     $time, exp_word.word, out_digest_word);
          end
          if (out_word_index !== exp_word.idx) begin
            errors++;
            $display("%0t: word_index mismatch: expected %0d, actual %0d",
                     $time, exp_word.idx, out_word_index);
          end
          if (out_last !== exp_word.last) begin
            errors++;
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, exp_word.last, out_last);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_func == FUNC_FINISH) finish_message();
        else absorb_byte(in_data_byte);
      end
    end
    fail_count  <= errors;
    pending_cnt <= digest_q.size();
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams byte messages of assorted lengths into the SHA-1 core with bursty
// requests and a stalling digest sink; the checker predicts every digest.
// ----------------------------------------------------------------------------

module testbench;
  import sha1sh_pkg::*;

  localparam int RANDOM_ITEMS = 160;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 250;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_cnt;
  int   cycle_cnt;
  int   burst_left;
  int   items_sent;
  int   sink_phase;
  int   sink_mode;
  int   msg_len;
  logic [7:0] sink_pattern;

  sha1sh_in_if  in_ch ();
  sha1sh_out_if out_ch ();

  sha1_stream_hash_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sha1sh_digest_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_func         (in_ch.func),
    .in_data_byte    (in_ch.data_byte),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_digest_word (out_ch.digest_word),
    .out_word_index  (out_ch.word_index),
    .out_last        (out_ch.last),
    .fail_count      (fail_count),
    .pending_cnt     (pending_cnt)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run-away guard
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // digest sink: switches between always ready, random and a repeating pattern
  initial begin
    out_ch.ready = 1'b0;
    sink_phase = 0;
    sink_mode = 0;
    sink_pattern = 8'hff;
  end
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (sink_phase % 32 == 0) begin
        sink_mode = $urandom_range(0, 2);
        sink_pattern = 8'($urandom);
        if (sink_pattern == 8'h00) sink_pattern = 8'h01;
      end
      case (sink_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= sink_pattern[sink_phase % 8];
      endcase
      sink_phase++;
    end
  end

  // one request, inside bursts separated by random gaps
  task automatic send_request(input logic func, input logic [7:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.func      <= func;
    in_ch.data_byte <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // hold the request side until every queued digest word has come out
  task automatic wait_digests_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_cnt != 0);
  endtask

  task automatic send_random_message(input int len);
    int i;
    for (i = 0; i < len; i++) send_request(FUNC_ABSORB, 8'($urandom));
    send_request(FUNC_FINISH, 8'($urandom));
  endtask

  function automatic int pick_length();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom_range(0, 12);
    if (sel < 8) return $urandom_range(50, 70);
    if (sel == 8) return $urandom_range(118, 130);
    return 0;
  endfunction

  // stimulus and verdict
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_ABSORB;
    in_ch.data_byte = 8'h00;
    burst_left = 0;
    items_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message, then empty again with a nonzero ignored byte
    send_request(FUNC_FINISH, 8'h00);
    send_request(FUNC_FINISH, 8'hff);
    // "abc"
    send_request(FUNC_ABSORB, 8'h61);
    send_request(FUNC_ABSORB, 8'h62);
    send_request(FUNC_ABSORB, 8'h63);
    send_request(FUNC_FINISH, 8'h5a);
    // extreme and alternating byte values
    send_request(FUNC_ABSORB, 8'h00);
    send_request(FUNC_ABSORB, 8'hff);
    send_request(FUNC_ABSORB, 8'h55);
    send_request(FUNC_ABSORB, 8'haa);
    send_request(FUNC_FINISH, 8'ha5);
    wait_digests_drained();

    // random messages, clustered around the one- and two-block padding edge
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      // keep the last message inside the item budget
      msg_len = pick_length();
      if (msg_len > RANDOM_ITEMS - items_sent - 1) msg_len = RANDOM_ITEMS - items_sent - 1;
      send_random_message(msg_len);
      if ($urandom_range(0, 3) == 0) wait_digests_drained();
    end
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (pending_cnt != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
